// ===== sv/bpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types and codes for the battery presence detector.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 8;

  // Rule that decided a sample
  typedef enum logic [2:0] {
    DEC_STRONG    = 3'd0,
    DEC_HUNT      = 3'd1,
    DEC_UNDERVOLT = 3'd2,
    DEC_OPENED    = 3'd3,
    DEC_ACCUM     = 3'd4,
    DEC_SWING     = 3'd5,
    DEC_CALM      = 3'd6
  } decision_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STRONG_CURRENT = 3'd0,
    REG_HUNT_LOW       = 3'd1,
    REG_HUNT_HIGH      = 3'd2,
    REG_MIN_RAIL       = 3'd3,
    REG_WINDOW_LENGTH  = 3'd4,
    REG_SWING_LIMIT    = 3'd5,
    REG_CALM_NEEDED    = 3'd6,
    REG_CHARGE_CURRENT = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        [14:0] strong_current_ma;
    logic signed [15:0] hunt_low_ma;
    logic signed [15:0] hunt_high_ma;
    logic        [14:0] min_rail_mv;
    logic        [31:0] window_length_us;
    logic        [14:0] swing_limit_mv;
    logic        [1:0]  calm_windows_needed;
    logic signed [15:0] charge_current_ma;
  } cfg_t;

  typedef struct packed {
    logic        present_flag;
    logic [1:0]  calm_count;
    logic        window_open;
    logic [31:0] window_start_us;
    logic [14:0] window_min_mv;
    logic [14:0] window_max_mv;
  } state_t;

  typedef struct packed {
    logic [31:0]        sample_time_us;
    logic [14:0]        rail_voltage_mv;
    logic               charger_status;
    logic signed [15:0] pack_current_ma;
  } sample_t;

  typedef struct packed {
    decision_e decision_code;
    logic      battery_charging;
    logic      battery_present;
  } result_t;

  localparam cfg_t CfgReset = '{
    strong_current_ma:   15'd25,
    hunt_low_ma:         -16'sd10,
    hunt_high_ma:        16'sd15,
    min_rail_mv:         15'd6000,
    window_length_us:    32'd1000000,
    swing_limit_mv:      15'd400,
    calm_windows_needed: 2'd2,
    charge_current_ma:   16'sd15
  };

endpackage

// ===== sv/bpd_rules.sv =====
// ----------------------------------------------------------------------------
// bpd_rules
// One pass of the presence rules: next detector state and the result.
// ----------------------------------------------------------------------------
module bpd_rules
  import bpd_pkg::*;
(
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  sample_t sample_i,
  output state_t  state_o,
  output result_t result_o
);

  logic signed [16:0] cur_x;
  logic signed [16:0] strong_pos;
  logic signed [16:0] strong_neg;
  logic               is_strong;
  logic               is_hunt;
  logic               is_undervolt;
  logic [14:0]        mv;
  logic [14:0]        min_upd;
  logic [14:0]        max_upd;
  logic [14:0]        swing;
  logic [31:0]        elapsed;
  logic               window_done;
  logic [1:0]         calm_inc;
  decision_e          code;

  assign mv         = sample_i.rail_voltage_mv;
  assign cur_x      = {sample_i.pack_current_ma[15], sample_i.pack_current_ma};
  assign strong_pos = $signed({2'b00, cfg_i.strong_current_ma});
  assign strong_neg = -strong_pos;

  assign is_strong    = (cur_x >= strong_pos) || (cur_x <= strong_neg);
  assign is_hunt      = sample_i.charger_status
                        && (sample_i.pack_current_ma > cfg_i.hunt_low_ma)
                        && (sample_i.pack_current_ma < cfg_i.hunt_high_ma);
  assign is_undervolt = mv < cfg_i.min_rail_mv;

  assign min_upd     = (mv < state_i.window_min_mv) ? mv : state_i.window_min_mv;
  assign max_upd     = (mv > state_i.window_max_mv) ? mv : state_i.window_max_mv;
  assign swing       = max_upd - min_upd;
  assign elapsed     = sample_i.sample_time_us - state_i.window_start_us;
  assign window_done = !(elapsed < cfg_i.window_length_us);

  // calm_count only climbs while below the threshold, so it never wraps
  assign calm_inc = (state_i.calm_count < cfg_i.calm_windows_needed)
                    ? state_i.calm_count + 2'd1 : state_i.calm_count;

  always_comb begin
    state_o = state_i;
    code    = DEC_ACCUM;
    if (is_strong) begin
      state_o.present_flag = 1'b1;
      state_o.calm_count   = cfg_i.calm_windows_needed;
      state_o.window_open  = 1'b0;
      code                 = DEC_STRONG;
    end else if (is_hunt || is_undervolt) begin
      state_o.present_flag = 1'b0;
      state_o.calm_count   = 2'd0;
      state_o.window_open  = 1'b0;
      code                 = is_hunt ? DEC_HUNT : DEC_UNDERVOLT;
    end else if (!state_i.window_open) begin
      state_o.window_open     = 1'b1;
      state_o.window_start_us = sample_i.sample_time_us;
      state_o.window_min_mv   = mv;
      state_o.window_max_mv   = mv;
      code                    = DEC_OPENED;
    end else if (!window_done) begin
      state_o.window_min_mv = min_upd;
      state_o.window_max_mv = max_upd;
      code                  = DEC_ACCUM;
    end else begin
      // window closes and the next one opens on this sample
      state_o.window_start_us = sample_i.sample_time_us;
      state_o.window_min_mv   = mv;
      state_o.window_max_mv   = mv;
      if (swing >= cfg_i.swing_limit_mv) begin
        state_o.present_flag = 1'b0;
        state_o.calm_count   = 2'd0;
        code                 = DEC_SWING;
      end else begin
        state_o.calm_count = calm_inc;
        if (calm_inc >= cfg_i.calm_windows_needed) begin
          state_o.present_flag = 1'b1;
        end
        code = DEC_CALM;
      end
    end
  end

  assign result_o.battery_present  = state_o.present_flag;
  assign result_o.battery_charging = state_o.present_flag
                                     && (sample_i.pack_current_ma >= cfg_i.charge_current_ma);
  assign result_o.decision_code    = code;

endmodule

// ===== sv/battery_presence_detector.sv =====
// ----------------------------------------------------------------------------
// battery_presence_detector
// Decides battery presence and charging from a stream of poll samples.
// ----------------------------------------------------------------------------
// Each sample transfer (pack current, charger status, rail voltage, timestamp)
// yields exactly one result transfer (present, charging, decision code), in
// order. A strong current in either direction marks the pack present; a
// charger hunting inside its current band or a rail below the minimum marks it
// absent and closes the voltage window; otherwise the rail min/max is tracked
// over a timed window, and at window close a large swing clears presence while
// enough consecutive calm windows set it. Elapsed time is the timestamp
// difference modulo 2^32. Throughput is one sample per clock while the result
// stream is not stalled. A sample waits in the input register until one pass
// of the rule logic loads its result into the result register, which happens
// when that register is free or being drained. The detector state is updated
// as each sample leaves the input register, so consecutive samples see each
// other's effect with no bubble. Configuration writes take effect on the next
// edge and are intended only while no sample is in flight.
// ----------------------------------------------------------------------------
module battery_presence_detector
  import bpd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // sample stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [15:0] pack_current_ma, [16] charger_status, [31:17] rail_voltage_mv,
  // [63:32] sample_time_us
  input  logic [InDataW-1:0]  s_axis_tdata,
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [0] battery_present, [1] battery_charging, [4:2] decision_code, [7:5] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  sample_t in_q;
  logic    in_valid_q;
  result_t res_d;
  result_t res_q;
  logic    out_valid_q;
  logic    advance;
  logic    take_in;

  // A sample moves to the result register when that register is free or
  // being drained this cycle; the input register refills in the same cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_STRONG_CURRENT: cfg_q.strong_current_ma   <= cfg_wdata_i[14:0];
        REG_HUNT_LOW:       cfg_q.hunt_low_ma         <= $signed(cfg_wdata_i[15:0]);
        REG_HUNT_HIGH:      cfg_q.hunt_high_ma        <= $signed(cfg_wdata_i[15:0]);
        REG_MIN_RAIL:       cfg_q.min_rail_mv         <= cfg_wdata_i[14:0];
        REG_WINDOW_LENGTH:  cfg_q.window_length_us    <= cfg_wdata_i[31:0];
        REG_SWING_LIMIT:    cfg_q.swing_limit_mv      <= cfg_wdata_i[14:0];
        REG_CALM_NEEDED:    cfg_q.calm_windows_needed <= cfg_wdata_i[1:0];
        REG_CHARGE_CURRENT: cfg_q.charge_current_ma   <= $signed(cfg_wdata_i[15:0]);
        default:            cfg_q                     <= cfg_q;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= s_axis_tdata;
    end
  end

  // Rule evaluation
  bpd_rules u_rules (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .sample_i (in_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Detector state, updated once per sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, res_q};

  // Absent decisions never report presence
  a_absent_codes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.decision_code == DEC_HUNT
                    || res_q.decision_code == DEC_UNDERVOLT
                    || res_q.decision_code == DEC_SWING)
    |-> !res_q.battery_present)
    else $error("absent decision reported present");

  a_strong_present : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.decision_code == DEC_STRONG) |-> res_q.battery_present)
    else $error("strong current did not set presence");

  a_charging_present : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.battery_charging |-> res_q.battery_present)
    else $error("charging without presence");

  a_window_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.window_open |-> (state_q.window_max_mv >= state_q.window_min_mv))
    else $error("window max below min");

  a_open_after_accum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_d.decision_code == DEC_OPENED || res_d.decision_code == DEC_ACCUM)
    |=> state_q.window_open)
    else $error("window not open after opening or accumulating sample");

endmodule

// ===== verif/bpd_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpd_scoreboard_pkg
// Presence decision predictor and result checker for the detector bench.
// ----------------------------------------------------------------------------
package bpd_scoreboard_pkg;

  import bpd_pkg::*;

  class presence_scoreboard;

    cfg_t        cfg;
    state_t      st;
    result_t     pending_decisions[$];
    int unsigned errors;

    function new();
      cfg = CfgReset;
      st = '0;
      errors = 0;
    endfunction

    // Runs the decision rules on an accepted sample, queues the outcome
    function void note_sample(sample_t s);
      int          cur;
      int          strong_ma;
      logic [31:0] elapsed;
      logic [14:0] swing;
      result_t     r;
      cur = $signed(s.pack_current_ma);
      strong_ma = int'(cfg.strong_current_ma);
      if (cur >= strong_ma || cur <= -strong_ma) begin
        st.present_flag = 1'b1;
        st.calm_count = cfg.calm_windows_needed;
        st.window_open = 1'b0;
        r.decision_code = DEC_STRONG;
      end else if (s.charger_status && cur > int'($signed(cfg.hunt_low_ma)) &&
                   cur < int'($signed(cfg.hunt_high_ma))) begin
        st.present_flag = 1'b0;
        st.calm_count = '0;
        st.window_open = 1'b0;
        r.decision_code = DEC_HUNT;
      end else if (s.rail_voltage_mv < cfg.min_rail_mv) begin
        st.present_flag = 1'b0;
        st.calm_count = '0;
        st.window_open = 1'b0;
        r.decision_code = DEC_UNDERVOLT;
      end else if (!st.window_open) begin
        st.window_open = 1'b1;
        st.window_start_us = s.sample_time_us;
        st.window_min_mv = s.rail_voltage_mv;
        st.window_max_mv = s.rail_voltage_mv;
        r.decision_code = DEC_OPENED;
      end else begin
        if (s.rail_voltage_mv < st.window_min_mv) st.window_min_mv = s.rail_voltage_mv;
        if (s.rail_voltage_mv > st.window_max_mv) st.window_max_mv = s.rail_voltage_mv;
        elapsed = s.sample_time_us - st.window_start_us;
        if (elapsed < cfg.window_length_us) begin
          r.decision_code = DEC_ACCUM;
        end else begin
          swing = st.window_max_mv - st.window_min_mv;
          st.window_start_us = s.sample_time_us;
          st.window_min_mv = s.rail_voltage_mv;
          st.window_max_mv = s.rail_voltage_mv;
          if (swing >= cfg.swing_limit_mv) begin
            st.present_flag = 1'b0;
            st.calm_count = '0;
            r.decision_code = DEC_SWING;
          end else begin
            if (st.calm_count < cfg.calm_windows_needed) st.calm_count = st.calm_count + 2'd1;
            if (st.calm_count >= cfg.calm_windows_needed) st.present_flag = 1'b1;
            r.decision_code = DEC_CALM;
          end
        end
      end
      r.battery_present = st.present_flag;
      r.battery_charging = st.present_flag && (cur >= int'($signed(cfg.charge_current_ma)));
      pending_decisions.push_back(r);
    endfunction

    function void check_result(logic [OutDataW-1:0] raw);
      result_t got;
      result_t want;
      got = result_t'(raw[4:0]);
      if (pending_decisions.size() == 0) begin
        $error("result transfer with no sample outstanding: tdata %h", raw);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (got.battery_present !== want.battery_present) begin
          $error("battery_present expected %0d actual %0d",
                 want.battery_present, got.battery_present);
          errors++;
        end
        if (got.battery_charging !== want.battery_charging) begin
          $error("battery_charging expected %0d actual %0d",
                 want.battery_charging, got.battery_charging);
          errors++;
        end
        if (got.decision_code !== want.decision_code) begin
          $error("decision_code expected %0d actual %0d",
                 want.decision_code, got.decision_code);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_decisions.size();
    endfunction

  endclass

endpackage

// ===== verif/battery_presence_detector_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// battery_presence_detector_test
// Self-checking bench for the battery presence detector.
// ----------------------------------------------------------------------------
// A directed pass walks the rule boundaries under the reset settings (strong
// current both ways, hunting band edges, undervoltage edge, swing at the
// limit, timestamp wrap, lowered calm threshold), then phases with extreme
// and random settings stream mostly well-formed poll sequences: a running
// timestamp, rail voltage near a base, weak currents, with strong, hunting,
// undervoltage and pure noise samples mixed in. Every sample transfer is run
// through the scoreboard's predictor; every result transfer is checked
// against the oldest prediction.
// ----------------------------------------------------------------------------
module battery_presence_detector_test;

  import bpd_pkg::*;
  import bpd_scoreboard_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned RxHoldCycles = 300;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [15:0] pack_current_ma, [16] charger_status, [31:17] rail_voltage_mv,
  // [63:32] sample_time_us
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [0] battery_present, [1] battery_charging, [4:2] decision_code, [7:5] zero
  logic [OutDataW-1:0] m_axis_tdata;

  presence_scoreboard sb = new();

  // stimulus knobs shared between the sender and the receiver
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;
  bit          hold_rx    = 1'b0;
  logic [31:0] t_cursor   = '0;
  int          v_base     = 0;

  battery_presence_detector dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("battery_presence_detector: mismatch");
    $finish;
  end

  // Transfer monitor. Reads the values from before the edge, so the order in
  // which processes wake at the edge does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(sample_t'(s_axis_tdata));
    end
  end

  // Result side backpressure: random ready bursts and stall bursts, a long
  // hold-off on request, and always-ready once idling is switched off.
  initial begin
    forever begin
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (!rx_idle_en || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
    end
  end

  // Offers one sample and holds it until the transfer; may then idle.
  // Called right after a rising edge.
  task automatic send_sample(input sample_t s);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    do @(posedge clk_i); while (!s_axis_tready);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Sender pause until every predicted result has been seen.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write; the enable is left high so back-to-back writes need
  // only one assignment per edge. The caller lowers it.
  task automatic put_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Writes all eight registers; unused upper bits carry junk on purpose.
  task automatic apply_config(input cfg_t c);
    put_reg(REG_STRONG_CURRENT, {17'($urandom), c.strong_current_ma});
    put_reg(REG_HUNT_LOW,       {16'($urandom), c.hunt_low_ma});
    put_reg(REG_HUNT_HIGH,      {16'($urandom), c.hunt_high_ma});
    put_reg(REG_MIN_RAIL,       {17'($urandom), c.min_rail_mv});
    put_reg(REG_WINDOW_LENGTH,  c.window_length_us);
    put_reg(REG_SWING_LIMIT,    {17'($urandom), c.swing_limit_mv});
    put_reg(REG_CALM_NEEDED,    {30'($urandom), c.calm_windows_needed});
    put_reg(REG_CHARGE_CURRENT, {16'($urandom), c.charge_current_ma});
    cfg_we_i <= 1'b0;
    sb.cfg = c;
  endtask

  function automatic sample_t mk_sample(input int cur, input bit chg, input int mv,
                                        input logic [31:0] t);
    sample_t s;
    s.pack_current_ma = 16'(cur);
    s.charger_status  = chg;
    s.rail_voltage_mv = 15'(mv);
    s.sample_time_us  = t;
    return s;
  endfunction

  // Mostly plausible polling: time moves forward by a fraction of the
  // window, voltage wanders above a base by less or more than the swing
  // limit. The rest are strong, hunting, undervoltage and pure noise.
  function automatic sample_t random_sample();
    sample_t     s;
    int          strong_ma;
    int          lo;
    int          hi;
    int          mv;
    int          spread;
    int unsigned pick;
    longint      step_max;
    strong_ma = int'(sb.cfg.strong_current_ma);
    lo = $signed(sb.cfg.hunt_low_ma);
    hi = $signed(sb.cfg.hunt_high_ma);
    pick = $urandom_range(0, 99);
    s = sample_t'({$urandom, $urandom});
    if (pick < 10) return s;
    if (strong_ma > 1) begin
      s.pack_current_ma = 16'(int'($urandom_range(0, 2*strong_ma - 2)) - (strong_ma - 1));
    end
    s.charger_status = ($urandom_range(0, 3) == 0);
    if (pick < 20) begin
      mv = strong_ma + int'($urandom_range(0, 32767 - strong_ma));
      if ($urandom_range(0, 15) == 0) s.pack_current_ma = 16'h8000;
      else s.pack_current_ma = 16'($urandom_range(0, 1) ? mv : -mv);
    end else if (pick < 26 && hi - lo >= 2) begin
      s.charger_status = 1'b1;
      s.pack_current_ma = 16'(lo + 1 + int'($urandom_range(0, hi - lo - 2)));
    end
    if (pick >= 26 && pick < 32 && sb.cfg.min_rail_mv != 0) begin
      mv = int'($urandom_range(0, int'(sb.cfg.min_rail_mv) - 1));
    end else begin
      spread = ($urandom_range(0, 5) == 0) ? int'(sb.cfg.swing_limit_mv) + 50
                                           : int'(sb.cfg.swing_limit_mv) / 2;
      mv = v_base + int'($urandom_range(0, spread));
      if (mv > 32767) mv = 32767;
    end
    s.rail_voltage_mv = 15'(mv);
    step_max = longint'(sb.cfg.window_length_us) / 2 + 1;
    if (step_max > 64'hFFFF_FFFF) step_max = 64'hFFFF_FFFF;
    t_cursor = t_cursor + $urandom_range(0, 32'(step_max));
    s.sample_time_us = t_cursor;
    return s;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.strong_current_ma   = 15'($urandom_range(30, 3000));
    c.hunt_low_ma         = 16'(-int'($urandom_range(0, 60)));
    c.hunt_high_ma        = 16'($urandom_range(0, 60));
    c.min_rail_mv         = 15'($urandom_range(0, 9000));
    c.window_length_us    = $urandom_range(1, 3000);
    c.swing_limit_mv      = 15'($urandom_range(1, 800));
    c.calm_windows_needed = 2'($urandom_range(0, 3));
    c.charge_current_ma   = 16'(int'($urandom_range(0, 300)) - 150);
    if ($urandom_range(0, 3) == 0) c.window_length_us = $urandom;
    return c;
  endfunction

  // One phase: settle, reprogram, then stream. With squeeze set, the
  // receiver holds off while the sender keeps offering back to back, so
  // the block fills and stalls its input.
  task automatic run_phase(input cfg_t c, input int n, input bit squeeze);
    drain();
    apply_config(c);
    v_base = int'(c.min_rail_mv) + int'($urandom_range(0, 500));
    if (v_base > 32767) v_base = 32767;
    t_cursor = $urandom;
    if (squeeze) begin
      tx_idle_en = 1'b0;
      hold_rx = 1'b1;
      repeat (60) send_sample(random_sample());
      tx_idle_en = 1'b1;
      n = n - 60;
    end
    repeat (n) send_sample(random_sample());
  endtask

  initial begin
    cfg_t c;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: strong 25, hunt (-10,15), rail 6000, window 1 s,
    // swing 400, two calm windows, charging from 15 mA.
    send_sample(mk_sample(0, 0, 7000, 100));          // window opens
    send_sample(mk_sample(10, 0, 7100, 200));         // accumulating
    send_sample(mk_sample(0, 0, 7050, 1000200));      // first calm window
    send_sample(mk_sample(20, 0, 7000, 2000200));     // second calm, present
    send_sample(mk_sample(32767, 0, 0, 0));           // strong, extremes
    send_sample(mk_sample(-32768, 1, 32767, 32'hFFFF_FFFF));
    send_sample(mk_sample(24, 0, 7000, 300));         // just below strong
    send_sample(mk_sample(-24, 1, 6000, 400));        // outside hunt band
    send_sample(mk_sample(0, 1, 7000, 500));          // hunting
    send_sample(mk_sample(-10, 1, 7000, 600));        // low band edge, open
    send_sample(mk_sample(14, 1, 7000, 700));         // hunting
    send_sample(mk_sample(15, 1, 7000, 800));         // high band edge
    send_sample(mk_sample(0, 0, 5999, 900));          // undervoltage
    send_sample(mk_sample(25, 0, 5999, 1000));        // strong at threshold
    send_sample(mk_sample(-25, 0, 6000, 1100));
    // window across the timestamp wrap, swing exactly at the limit
    send_sample(mk_sample(0, 0, 6000, 32'hFFFF_FF00));
    send_sample(mk_sample(0, 0, 6400, 32'hFFFF_FF00 + 32'd999999));
    send_sample(mk_sample(0, 0, 6000, 32'hFFFF_FF00 + 32'd1000000));
    send_sample(mk_sample(0, 0, 6399, 32'hFFFF_FF00 + 32'd2000000));

    // Lowered calm threshold: count loaded to 3 by a strong current, then
    // the threshold drops to 1 and a calm window must still set presence.
    drain();
    c = CfgReset;
    c.calm_windows_needed = 2'd3;
    apply_config(c);
    send_sample(mk_sample(-100, 0, 7000, 0));
    drain();
    c.calm_windows_needed = 2'd1;
    apply_config(c);
    send_sample(mk_sample(0, 0, 7000, 10));
    send_sample(mk_sample(0, 0, 7000, 1000010));

    // Extremes: zero window, zero calm windows, widest hunt band.
    c.strong_current_ma   = 15'd32767;
    c.hunt_low_ma         = 16'sh8000;
    c.hunt_high_ma        = 16'sh7FFF;
    c.min_rail_mv         = 15'd0;
    c.window_length_us    = 32'd0;
    c.swing_limit_mv      = 15'd32767;
    c.calm_windows_needed = 2'd0;
    c.charge_current_ma   = 16'sh8000;
    run_phase(c, 60, 1'b0);

    // Extremes the other way: longest window, zero swing limit, empty band.
    c.hunt_low_ma         = 16'sd0;
    c.hunt_high_ma        = 16'sd0;
    c.min_rail_mv         = 15'd32767;
    c.window_length_us    = 32'hFFFF_FFFF;
    c.swing_limit_mv      = 15'd0;
    c.calm_windows_needed = 2'd3;
    c.charge_current_ma   = 16'sh7FFF;
    run_phase(c, 50, 1'b0);

    // Zero strong threshold: every sample is a strong current.
    c.strong_current_ma = 15'd0;
    run_phase(c, 20, 1'b0);

    run_phase(random_config(), 130, 1'b0);
    run_phase(random_config(), 130, 1'b1);
    run_phase(random_config(), 130, 1'b0);
    run_phase(random_config(), 130, 1'b0);
    run_phase(random_config(), 130, 1'b0);

    // Closing stretch at full rate on both sides.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(random_config(), 130, 1'b0);

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("battery_presence_detector: match");
    end else begin
      $display("battery_presence_detector: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bpd_pkg.sv
sv/bpd_rules.sv
sv/battery_presence_detector.sv
verif/bpd_scoreboard_pkg.sv
verif/battery_presence_detector_test.sv
